// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the lidar packet parser.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property must never hold at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// File: rtl/core/lpp_pkg.sv
// Shared constants, codes and types of the lidar packet parser.
// No dependencies; imported by the assembler, the table, the top level and the bench.
package lpp_pkg;

    localparam int PKT_LEN     = 22;
    localparam int N_READINGS  = 4;
    localparam int TABLE_DEPTH = 360;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ACC_W       = 26;   // ten folded words stay below 2^26

    localparam logic [7:0] START_BYTE = 8'hFA;
    localparam logic [7:0] ANGLE_LO   = 8'hA0;
    localparam logic [7:0] ANGLE_HI   = 8'hF9;
    localparam logic [7:0] FLAG_MASK  = 8'hC0;  // invalid | warning

    // request and result kinds
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_READ    = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CSUM  = 2'd1,
        ST_ANGLE = 2'd2
    } t_status;

    typedef logic [13:0] t_dist;

    // packet view seen while the last byte is on the input
    typedef struct packed {
        logic                        last;
        t_status                     status;
        logic [ADDR_W-1:0]           base;
        logic [15:0]                 speed;
        t_dist [N_READINGS-1:0]      vals;
        logic [2:0]                  n_good;
    } t_pkt;

    // table engine status
    typedef struct packed {
        logic              busy;
        logic              clearing;
        logic [ADDR_W-1:0] nonzero;
    } t_tbl_stat;

endpackage

// File: rtl/core/lpp_assembler.sv
// Byte hunter and packet assembler: start-byte search, packet store and checksum fold.
// Depends on lpp_pkg.
module lpp_assembler
    import lpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_go,
    input  logic [7:0] i_rx_byte,
    output t_pkt       o_pkt
);

    logic             r_in_pkt;
    logic [4:0]       r_pos;
    logic [7:0]       r_store [PKT_LEN-1];
    logic [7:0]       r_lo;
    logic [ACC_W-1:0] r_acc;

    // framing: start-byte search and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pkt <= 1'b0;
            r_pos    <= '0;
        end else if (i_byte_go) begin
            if (!r_in_pkt) begin
                if (i_rx_byte == START_BYTE) begin
                    r_in_pkt <= 1'b1;
                    r_pos    <= 5'd1;
                end
            end else if (r_pos == 5'(PKT_LEN-1)) begin
                r_in_pkt <= 1'b0;
                r_pos    <= '0;
            end else begin
                r_pos <= r_pos + 5'd1;
            end
        end
    end

    // packet bytes and checksum words, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_byte_go) begin
            if (!r_in_pkt) begin
                if (i_rx_byte == START_BYTE) begin
                    r_store[0] <= i_rx_byte;
                    r_lo       <= i_rx_byte;
                    r_acc      <= '0;
                end
            end else if (r_pos != 5'(PKT_LEN-1)) begin
                r_store[r_pos] <= i_rx_byte;
                if (!r_pos[0]) begin
                    r_lo <= i_rx_byte;
                end else begin
                    r_acc <= ACC_W'({r_acc, 1'b0} + {11'b0, i_rx_byte, r_lo});
                end
            end
        end
    end

    // decode of the finished packet while its last byte is presented
    always_comb begin
        logic [15:0] fold;
        logic [15:0] given;
        logic [7:0]  ang_off;
        logic        ang_ok;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic        bad;
        logic [2:0]  good_cnt;

        fold     = {1'b0, r_acc[14:0]} + {5'b0, r_acc[ACC_W-1:15]};
        given    = {i_rx_byte, r_store[PKT_LEN-2]};
        ang_ok   = (r_store[1] >= ANGLE_LO) && (r_store[1] <= ANGLE_HI);
        ang_off  = r_store[1] - ANGLE_LO;
        good_cnt = '0;

        o_pkt.last  = r_in_pkt && (r_pos == 5'(PKT_LEN-1));
        o_pkt.base  = {ang_off[6:0], 2'b00};
        o_pkt.speed = {r_store[3], r_store[2]};

        for (int i = 0; i < N_READINGS; i++) begin
            lo  = r_store[4 + 4*i];
            hi  = r_store[5 + 4*i];
            bad = (hi & FLAG_MASK) != 8'h00;
            o_pkt.vals[i] = bad ? '0 : {hi[5:0], lo};
            good_cnt = good_cnt + {2'b0, !bad};
        end
        o_pkt.n_good = good_cnt;

        if (given != {1'b0, fold[14:0]}) begin
            o_pkt.status = ST_CSUM;
        end else if (!ang_ok) begin
            o_pkt.status = ST_ANGLE;
        end else begin
            o_pkt.status = ST_OK;
        end
    end

endmodule

// File: rtl/core/lpp_table.sv
// Distance table: 360-entry memory with clearing pass, read-modify-write of the
// four readings of a packet, single reads, and the count of nonzero entries.
// Depends on lpp_pkg.
module lpp_table
    import lpp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_go,
    input  logic [ADDR_W-1:0]      i_job_base,
    input  t_dist [N_READINGS-1:0] i_job_vals,
    input  logic                   i_rd_go,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    output t_dist                  o_rd_data,
    output t_tbl_stat              o_stat
);

    t_dist                  r_mem [TABLE_DEPTH];
    t_dist                  r_rdata;
    logic                   r_clr_act;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic                   r_iss_act;
    logic [1:0]             r_iss_cnt;
    logic                   r_wb_act;
    logic [1:0]             r_wb_cnt;
    logic [ADDR_W-1:0]      r_base;
    t_dist [N_READINGS-1:0] r_vals;
    logic [ADDR_W-1:0]      r_nonzero;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_dist             wr_data;
    t_dist             wb_data;
    logic              was_nz;
    logic              now_nz;

    // port steering: issue stage reads, writeback stage writes the same entry in the following cycle
    always_comb begin
        wb_data = r_vals[r_wb_cnt];
        rd_en   = r_iss_act || i_rd_go;
        rd_addr = r_iss_act ? (r_base + ADDR_W'(r_iss_cnt)) : i_rd_addr;
        wr_en   = r_clr_act || r_wb_act;
        wr_addr = r_clr_act ? r_clr_addr : (r_base + ADDR_W'(r_wb_cnt));
        wr_data = r_clr_act ? '0 : wb_data;
        was_nz  = r_rdata != '0;
        now_nz  = wb_data != '0;
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // sequencing of clearing pass and packet jobs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_act  <= 1'b1;
            r_clr_addr <= '0;
            r_iss_act  <= 1'b0;
            r_iss_cnt  <= '0;
            r_wb_act   <= 1'b0;
            r_wb_cnt   <= '0;
            r_nonzero  <= '0;
        end else begin
            if (r_clr_act) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(TABLE_DEPTH-1)) begin
                    r_clr_act <= 1'b0;
                end
            end
            if (i_job_go) begin
                r_iss_act <= 1'b1;
                r_iss_cnt <= '0;
            end else if (r_iss_act) begin
                r_iss_cnt <= r_iss_cnt + 2'd1;
                if (r_iss_cnt == 2'(N_READINGS-1)) begin
                    r_iss_act <= 1'b0;
                end
            end
            r_wb_act <= r_iss_act;
            r_wb_cnt <= r_iss_cnt;
            // nonzero entry count follows each overwrite
            if (r_wb_act) begin
                if (was_nz && !now_nz) begin
                    r_nonzero <= r_nonzero - ADDR_W'(1);
                end else if (!was_nz && now_nz) begin
                    r_nonzero <= r_nonzero + ADDR_W'(1);
                end
            end
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (i_job_go) begin
            r_base <= i_job_base;
            r_vals <= i_job_vals;
        end
    end

    assign o_rd_data       = r_rdata;
    assign o_stat.busy     = r_iss_act || r_wb_act;
    assign o_stat.clearing = r_clr_act;
    assign o_stat.nonzero  = r_nonzero;

endmodule

// File: rtl/core/lidar_packet_parser_scan_table_top.sv
// Channel   | handshake                  | payload
// ----------+----------------------------+----------------------------------------------
// request   | i_in_valid / o_in_ready    | i_req_type, i_rx_byte, i_read_angle
// result    | o_out_valid / i_out_ready  | o_result_kind .. o_read_distance
//
// A table read uses the table read port, and its result is loaded into the output register
// in the following cycle, in which requests are held off. A completed good packet runs four
// read-modify-write accesses on the table ports (reads one per cycle, each write in the cycle
// after its read); while they run, reads and the next packet end wait. After reset the table
// is cleared one entry a cycle, with o_in_ready low. The output register holds a result until
// taken; new requests that need it wait while it is full.
//
// Top level of the lidar packet parser; depends on lpp_pkg, lpp_assembler, lpp_table.
module lidar_packet_parser_scan_table_top
    import lpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [8:0]  i_read_angle,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [1:0]  o_packet_status,
    output logic [8:0]  o_base_angle,
    output logic [15:0] o_rotation_speed,
    output logic [15:0] o_good_count,
    output logic [15:0] o_bad_count,
    output logic [8:0]  o_angles_covered,
    output logic [13:0] o_read_distance
);

    t_pkt      pkt;
    t_tbl_stat tstat;
    t_dist     rd_data;

    logic        is_read;
    logic        out_free;
    logic        in_acc;
    logic        pkt_done;
    logic        rd_go;
    logic        rd_oob;
    logic        job_go;

    logic [15:0]       r_speed, n_speed;
    logic [15:0]       r_good,  n_good;
    logic [15:0]       r_bad,   n_bad;
    logic [ADDR_W-1:0] r_snap,  n_snap;
    logic              r_rd_pend;
    logic              r_rd_oob;

    logic              r_o_valid;
    logic              r_o_kind;
    t_status           r_o_status;
    logic [ADDR_W-1:0] r_o_base;
    logic [15:0]       r_o_speed;
    logic [15:0]       r_o_good;
    logic [15:0]       r_o_bad;
    logic [ADDR_W-1:0] r_o_cov;
    t_dist             r_o_dist;

    lpp_assembler u_asm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_go (in_acc && !is_read),
        .i_rx_byte (i_rx_byte),
        .o_pkt     (pkt)
    );

    lpp_table u_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_go   (job_go),
        .i_job_base (pkt.base),
        .i_job_vals (pkt.vals),
        .i_rd_go    (rd_go && !rd_oob),
        .i_rd_addr  (i_read_angle),
        .o_rd_data  (rd_data),
        .o_stat     (tstat)
    );

    // acceptance: none while clearing or reading; packet ends and reads also need table and output
    always_comb begin
        is_read    = i_req_type == REQ_READ;
        out_free   = !r_o_valid || i_out_ready;
        o_in_ready = !tstat.clearing && !r_rd_pend &&
                     ((!is_read && !pkt.last) || (out_free && !tstat.busy));
        in_acc     = i_in_valid && o_in_ready;
        pkt_done   = in_acc && !is_read && pkt.last;
        rd_go      = in_acc && is_read;
        rd_oob     = i_read_angle >= 9'(TABLE_DEPTH);
        job_go     = pkt_done && (pkt.status == ST_OK);
    end

    // speed, counters and snapshot after a finished packet
    always_comb begin
        n_speed = r_speed;
        n_good  = r_good;
        n_bad   = r_bad;
        n_snap  = r_snap;
        if (pkt_done) begin
            case (pkt.status)
                ST_CSUM: begin
                    n_bad = r_bad + 16'd4;
                end
                ST_OK: begin
                    n_speed = pkt.speed;
                    if (pkt.base == '0) begin
                        n_snap = tstat.nonzero;
                        n_good = {13'b0, pkt.n_good};
                        n_bad  = {13'b0, 3'd4 - pkt.n_good};
                    end else begin
                        n_good = r_good + {13'b0, pkt.n_good};
                        n_bad  = r_bad + {13'b0, 3'd4 - pkt.n_good};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control registers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= '0;
            r_good    <= '0;
            r_bad     <= '0;
            r_snap    <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_speed   <= n_speed;
            r_good    <= n_good;
            r_bad     <= n_bad;
            r_snap    <= n_snap;
            r_rd_pend <= rd_go;
            if (pkt_done || r_rd_pend) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // output payload: packet report at once, read data in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_rd_oob <= rd_oob;
        end
        if (pkt_done) begin
            r_o_kind   <= KIND_REPORT;
            r_o_status <= pkt.status;
            r_o_base   <= (pkt.status == ST_OK) ? pkt.base : '0;
            r_o_speed  <= n_speed;
            r_o_good   <= n_good;
            r_o_bad    <= n_bad;
            r_o_cov    <= n_snap;
            r_o_dist   <= '0;
        end else if (r_rd_pend) begin
            r_o_kind   <= KIND_READ;
            r_o_status <= ST_OK;
            r_o_base   <= '0;
            r_o_speed  <= r_speed;
            r_o_good   <= r_good;
            r_o_bad    <= r_bad;
            r_o_cov    <= r_snap;
            r_o_dist   <= r_rd_oob ? '0 : rd_data;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_result_kind    = r_o_kind;
    assign o_packet_status  = r_o_status;
    assign o_base_angle     = r_o_base;
    assign o_rotation_speed = r_o_speed;
    assign o_good_count     = r_o_good;
    assign o_bad_count      = r_o_bad;
    assign o_angles_covered = r_o_cov;
    assign o_read_distance  = r_o_dist;

endmodule

// File: rtl/core/lpp_checker.sv
// Port-level checker of the lidar packet parser, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_result_kind,
    input logic [1:0]  o_packet_status,
    input logic [8:0]  o_base_angle,
    input logic [15:0] o_bad_count,
    input logic [8:0]  o_angles_covered,
    input logic [13:0] o_read_distance
);

    // a stalled result transaction keeps its distance and bad count
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_distance) && $stable(o_bad_count), "result changed while stalled")

    // table reads report status ok and no base angle
    `ASSERT_CLK(a_read_fields, i_clk, i_rst_n, o_out_valid && o_result_kind |-> o_packet_status == 2'd0 && o_base_angle == 9'd0, "read result with packet fields")

    // failed packets carry no angle and no distance
    `ASSERT_CLK(a_fail_fields, i_clk, i_rst_n, o_out_valid && !o_result_kind && o_packet_status != 2'd0 |-> o_base_angle == 9'd0 && o_read_distance == 14'd0, "failed packet with data")

    // status code three, oversized coverage and base angles above 356 never appear
    `ASSERT_NEVER(a_ranges, i_clk, i_rst_n, o_out_valid && (o_packet_status == 2'd3 || o_angles_covered > 9'd360 || o_base_angle > 9'd356), "result field out of range")

endmodule

bind lidar_packet_parser_scan_table_top lpp_checker u_lpp_checker (.*);

// File: bench/lidar_packet_parser_scan_table_top_tb.sv
// Self-checking bench for the lidar packet parser: random and directed bytes and table reads,
// checked against a cycle-free model of the packet and table behavior kept in the bench.
// Depends on lpp_pkg and lidar_packet_parser_scan_table_top.
module lidar_packet_parser_scan_table_top_tb;
    import lpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_ITEMS = 1950;
    localparam int TAIL_CYCLES  = 20;

    typedef logic [7:0]  t_pkt_bytes [PKT_LEN];
    typedef logic [15:0] t_readings  [N_READINGS];

    // one request transaction with the idle cycles that precede it
    typedef struct {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [8:0] read_angle;
        int         gap;
        bit         drain;
    } t_req;

    typedef struct packed {
        logic        kind;
        t_status     status;
        logic [8:0]  base;
        logic [15:0] speed;
        logic [15:0] good;
        logic [15:0] bad;
        logic [8:0]  covered;
        logic [13:0] rd_dist;
    } t_report;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_req_type   = 1'b0;
    logic [7:0]  i_rx_byte    = 8'h00;
    logic [8:0]  i_read_angle = 9'h000;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_result_kind;
    logic [1:0]  o_packet_status;
    logic [8:0]  o_base_angle;
    logic [15:0] o_rotation_speed;
    logic [15:0] o_good_count;
    logic [15:0] o_bad_count;
    logic [8:0]  o_angles_covered;
    logic [13:0] o_read_distance;

    // stimulus and expected reports
    t_req    pending[$];
    t_req    cur_req;
    t_report awaited[$];

    // shadow of the parser and table state
    logic        trk_in_pkt;
    int          trk_pos;
    t_pkt_bytes  trk_buf;
    logic [13:0] range_mm [TABLE_DEPTH];
    logic [8:0]  trk_nonzero;
    logic [8:0]  trk_snapshot;
    logic [15:0] trk_speed;
    logic [15:0] trk_good;
    logic [15:0] trk_bad;

    // generator bookkeeping
    int gen_pos;
    int n_items;
    int burst_left;
    bit drain_next;

    // run statistics
    int n_errors;
    int n_results;
    int n_reads;
    int n_by_status [3];

    // receiver stall control
    int hold_left;
    int calm_left;
    bit first_hold_done;
    bit second_hold_done;

    lidar_packet_parser_scan_table_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_rx_byte        (i_rx_byte),
        .i_read_angle     (i_read_angle),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_packet_status  (o_packet_status),
        .o_base_angle     (o_base_angle),
        .o_rotation_speed (o_rotation_speed),
        .o_good_count     (o_good_count),
        .o_bad_count      (o_bad_count),
        .o_angles_covered (o_angles_covered),
        .o_read_distance  (o_read_distance)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ten little-endian words folded by shift-and-add, wrapped into 15 bits
    function automatic logic [15:0] fold_checksum(input t_pkt_bytes p);
        logic [31:0] acc;
        logic [31:0] wrapped;
        acc = '0;
        for (int k = 0; k < 10; k++) begin
            acc = (acc << 1) + {16'h0000, p[2*k+1], p[2*k]};
        end
        wrapped = {17'h0, acc[14:0]} + (acc >> 15);
        return {1'b0, wrapped[14:0]};
    endfunction

    // table write that keeps the nonzero count in step
    task automatic write_entry(input int idx, input logic [13:0] val);
        if (range_mm[idx] != '0 && val == '0) trk_nonzero = trk_nonzero - 1'b1;
        if (range_mm[idx] == '0 && val != '0) trk_nonzero = trk_nonzero + 1'b1;
        range_mm[idx] = val;
    endtask

    // advance the shadow state by one accepted request and queue its report, if any
    task automatic track_request(input t_req r);
        t_report e;
        logic [7:0] lo;
        logic [7:0] hi;
        int base;
        e = '0;
        if (r.req_type == REQ_BYTE) begin
            if (!trk_in_pkt) begin
                if (r.rx_byte == START_BYTE) begin
                    trk_buf[0] = r.rx_byte;
                    trk_pos    = 1;
                    trk_in_pkt = 1'b1;
                end
                return;
            end
            trk_buf[trk_pos] = r.rx_byte;
            trk_pos++;
            if (trk_pos < PKT_LEN) return;
            trk_pos    = 0;
            trk_in_pkt = 1'b0;
            e.kind     = KIND_REPORT;
            if ({trk_buf[21], trk_buf[20]} != fold_checksum(trk_buf)) begin
                trk_bad  = trk_bad + 16'd4;
                e.status = ST_CSUM;
            end else if (trk_buf[1] < ANGLE_LO || trk_buf[1] > ANGLE_HI) begin
                e.status = ST_ANGLE;
            end else begin
                base      = (int'(trk_buf[1]) - int'(ANGLE_LO)) * 4;
                trk_speed = {trk_buf[3], trk_buf[2]};
                // angle-zero packet: snapshot coverage, restart counters
                if (base == 0) begin
                    trk_snapshot = trk_nonzero;
                    trk_good     = '0;
                    trk_bad      = '0;
                end
                for (int i = 0; i < N_READINGS; i++) begin
                    lo = trk_buf[4+4*i];
                    hi = trk_buf[5+4*i];
                    if ((hi & FLAG_MASK) == '0) begin
                        write_entry(base + i, {hi[5:0], lo});
                        trk_good = trk_good + 1'b1;
                    end else begin
                        write_entry(base + i, '0);
                        trk_bad = trk_bad + 1'b1;
                    end
                end
                e.status = ST_OK;
                e.base   = 9'(base);
            end
        end else begin
            e.kind    = KIND_READ;
            e.rd_dist = (r.read_angle < TABLE_DEPTH) ? range_mm[r.read_angle] : '0;
        end
        e.speed   = trk_speed;
        e.good    = trk_good;
        e.bad     = trk_bad;
        e.covered = trk_snapshot;
        awaited.push_back(e);
    endtask

    // mostly back-to-back or short gaps, a few long ones, and idle-free stretches
    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            burst_left = $urandom_range(40, 120);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_item(input logic req_type, input logic [7:0] b, input logic [8:0] ang);
        t_req r;
        r.req_type   = req_type;
        r.rx_byte    = b;
        r.read_angle = ang;
        r.gap        = next_gap();
        r.drain      = drain_next;
        drain_next   = 1'b0;
        pending.push_back(r);
    endtask

    // a byte; the generator tracks packet framing so later packets start aligned
    task automatic push_byte(input logic [7:0] b);
        if (gen_pos == 0) begin
            if (b == START_BYTE) begin
                gen_pos = 1;
                n_items++;
            end
        end else begin
            gen_pos = (gen_pos + 1 == PKT_LEN) ? 0 : gen_pos + 1;
            n_items++;
        end
        push_item(REQ_BYTE, b, 9'($urandom));
    endtask

    task automatic push_read(input logic [8:0] ang);
        n_items++;
        push_item(REQ_READ, 8'($urandom), ang);
    endtask

    function automatic logic [8:0] random_angle();
        if ($urandom_range(9) == 0) return 9'($urandom_range(TABLE_DEPTH, 511));
        return 9'($urandom_range(TABLE_DEPTH - 1));
    endfunction

    function automatic logic [15:0] random_reading();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'h0000;
        if (r < 75) return {2'b00, 14'($urandom)};
        return {2'($urandom_range(1, 3)), 14'($urandom)};
    endfunction

    // full packet; any partial packet left by noise is completed first
    task automatic send_packet(input logic [7:0] angle_code, input logic [15:0] speed,
                               input t_readings rd, input bit bad_sum, input bit mix_reads);
        t_pkt_bytes  p;
        logic [15:0] sum;
        while (gen_pos != 0) push_byte(8'($urandom));
        p[0]  = START_BYTE;
        p[1]  = angle_code;
        p[2]  = speed[7:0];
        p[3]  = speed[15:8];
        p[20] = 8'h00;
        p[21] = 8'h00;
        for (int i = 0; i < N_READINGS; i++) begin
            p[4+4*i] = rd[i][7:0];
            p[5+4*i] = rd[i][15:8];
        end
        sum = fold_checksum(p);
        if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(15));
        p[20] = sum[7:0];
        p[21] = sum[15:8];
        for (int k = 0; k < PKT_LEN; k++) begin
            if (mix_reads && $urandom_range(99) < 4) push_read(random_angle());
            push_byte(p[k]);
        end
    endtask

    task automatic send_random_packet(input logic [7:0] angle_code, input bit bad_sum);
        t_readings rd;
        for (int i = 0; i < N_READINGS; i++) rd[i] = random_reading();
        send_packet(angle_code, 16'($urandom), rd, bad_sum, 1'b1);
    endtask

    task automatic build_stimulus();
        int r;
        logic [7:0] code;
        // directed: empty table, ignored bytes, the angle extremes, flags, bad frames
        push_read(9'd0);
        push_read(9'd511);
        push_byte(8'h00);
        push_byte(8'hFF);
        send_packet(ANGLE_LO, 16'h12FA, '{16'h3FFF, 16'h0000, 16'h8123, 16'h4055}, 1'b0, 1'b0);
        send_packet(ANGLE_HI, 16'hFFFF, '{16'h0001, 16'hC0FF, 16'h2000, 16'h3FFF}, 1'b0, 1'b0);
        send_packet(8'hB4, 16'h0400, '{16'h0100, 16'h0200, 16'h0300, 16'h0400}, 1'b1, 1'b0);
        send_packet(8'h9F, 16'h7777, '{16'h0011, 16'h0022, 16'h0033, 16'h0044}, 1'b0, 1'b0);
        send_packet(8'hFA, 16'h5555, '{16'h0011, 16'h0022, 16'h0033, 16'h0044}, 1'b0, 1'b0);
        for (int a = 0; a < 4; a++) push_read(9'(a));
        push_read(9'd356);
        push_read(9'd359);
        push_read(9'd360);
        send_packet(ANGLE_LO, 16'h0000, '{16'h0000, 16'h0005, 16'h4000, 16'h0006}, 1'b0, 1'b0);
        // truncated frame that swallows the next start byte
        push_byte(START_BYTE);
        push_byte(8'hA4);
        push_byte(START_BYTE);

        // random part: mostly well-formed packets, some reads, noise and broken frames
        drain_next = 1'b1;
        while (n_items < TARGET_ITEMS) begin
            if (n_items > TARGET_ITEMS / 2 && n_items < TARGET_ITEMS / 2 + 30) drain_next = 1'b1;
            r = $urandom_range(99);
            if (r < 68) begin
                code = ($urandom_range(11) == 0) ? ANGLE_LO
                                                 : 8'($urandom_range(ANGLE_LO, ANGLE_HI));
                send_random_packet(code, 1'b0);
            end else if (r < 76) begin
                send_random_packet(8'($urandom_range(ANGLE_LO, ANGLE_HI)), 1'b1);
            end else if (r < 81) begin
                code = ($urandom_range(1) == 0) ? 8'($urandom_range(0, ANGLE_LO - 1))
                                                : 8'($urandom_range(ANGLE_HI + 1, 255));
                send_random_packet(code, 1'b0);
            end else if (r < 92) begin
                repeat ($urandom_range(1, 4)) push_read(random_angle());
            end else begin
                repeat ($urandom_range(1, 30)) push_byte(8'($urandom));
            end
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        logic nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                track_request(cur_req);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending.size() != 0) begin
                if (pending[0].drain && awaited.size() != 0) begin
                    // hold off until every report is back
                end else if (pending[0].gap > 0) begin
                    pending[0].gap = pending[0].gap - 1;
                end else begin
                    cur_req = pending.pop_front();
                    i_req_type   <= cur_req.req_type;
                    i_rx_byte    <= cur_req.rx_byte;
                    i_read_angle <= cur_req.read_angle;
                    nxt_valid = 1'b1;
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // result ready: random short stalls, calm stretches, two long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (!first_hold_done && n_results >= 40) begin
                first_hold_done = 1'b1;
                hold_left = 400;
            end
            if (!second_hold_done && n_results >= 150) begin
                second_hold_done = 1'b1;
                hold_left = 400;
            end
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(999) == 0) calm_left = $urandom_range(100, 400);
            if (hold_left > 0) begin
                hold_left--;
            end else if (calm_left == 0 && $urandom_range(99) < 12) begin
                hold_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
            end
            i_out_ready <= (hold_left == 0);
        end
    end

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // result monitor
    always @(posedge i_clk) begin
        t_report e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (awaited.size() == 0) begin
                $error("result transaction with no report outstanding");
                n_errors++;
            end else begin
                e = awaited.pop_front();
                if (e.kind == KIND_READ) n_reads++;
                else n_by_status[e.status]++;
                check_field("result_kind", e.kind, o_result_kind);
                check_field("packet_status", e.status, o_packet_status);
                check_field("base_angle", e.base, o_base_angle);
                check_field("rotation_speed", e.speed, o_rotation_speed);
                check_field("good_count", e.good, o_good_count);
                check_field("bad_count", e.bad, o_bad_count);
                check_field("angles_covered", e.covered, o_angles_covered);
                check_field("read_distance", e.rd_dist, o_read_distance);
            end
        end
    end

    initial begin
        trk_in_pkt   = 1'b0;
        trk_pos      = 0;
        trk_nonzero  = '0;
        trk_snapshot = '0;
        trk_speed    = '0;
        trk_good     = '0;
        trk_bad      = '0;
        for (int k = 0; k < PKT_LEN; k++) trk_buf[k] = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) range_mm[k] = '0;
        build_stimulus();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_in_valid) @(posedge i_clk);
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d counted requests; got %0d results: %0d table reads, packets ok %0d,",
                 n_items, n_results, n_reads, n_by_status[ST_OK]);
        $display("checksum errors %0d, angle errors %0d; %0d table entries nonzero at end.",
                 n_by_status[ST_CSUM], n_by_status[ST_ANGLE], trk_nonzero);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Timeout: %0d requests still queued, %0d reports outstanding",
                 pending.size(), awaited.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
